// ----- hw/rtl/epd_pkg.sv -----
`timescale 1ns / 1ps

package epd_pkg;

  // Link framing bytes
  localparam logic [7:0] SYNC_BYTE = 8'hE0;
  localparam logic [7:0] MARK_BYTE = 8'hD0;
  localparam logic [7:0] ESC_SYNC  = 8'hDF;
  localparam logic [7:0] ESC_MARK  = 8'hCF;

  // Deframer phases
  localparam logic [1:0] PH_SEEK  = 2'd0;
  localparam logic [1:0] PH_ADDR  = 2'd1;
  localparam logic [1:0] PH_COUNT = 2'd2;
  localparam logic [1:0] PH_DATA  = 2'd3;

  // Result kinds
  localparam logic [2:0] K_START   = 3'd0;
  localparam logic [2:0] K_PAYLOAD = 3'd1;
  localparam logic [2:0] K_GOOD    = 3'd2;
  localparam logic [2:0] K_CSUM    = 3'd3;
  localparam logic [2:0] K_ESC     = 3'd4;
  localparam logic [2:0] K_ZERO    = 3'd5;

  typedef struct packed {
    logic [1:0] phase;
    logic       esc_pending;
    logic [7:0] running_sum;
    logic [7:0] held_address;
    logic [7:0] held_count;
    logic [7:0] bytes_seen;
  } epd_state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] payload_value;
    logic [7:0] node_address;
    logic [7:0] length_field;
    logic [7:0] expected_sum;
    logic [7:0] received_sum;
  } epd_res_t;

  // Packet state with everything cleared, phase left to the caller
  function automatic epd_state_t epd_cleared(input logic [1:0] ph);
    epd_state_t s;
    s = '0;
    s.phase = ph;
    return s;
  endfunction

endpackage

// ----- hw/rtl/epd_ifs.sv -----
`timescale 1ns / 1ps

// Raw link byte channel
interface epd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink   (input valid, input raw_byte, output ready);
endinterface

// Deframer result channel
interface epd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] payload_value;
  logic [7:0] node_address;
  logic [7:0] length_field;
  logic [7:0] expected_sum;
  logic [7:0] received_sum;

  modport source (output valid, output kind, output payload_value, output node_address,
                  output length_field, output expected_sum, output received_sum,
                  input ready);
  modport sink   (input valid, input kind, input payload_value, input node_address,
                  input length_field, input expected_sum, input received_sum,
                  output ready);
endinterface

// ----- hw/rtl/epd_step.sv -----
`timescale 1ns / 1ps

// Per-byte deframing: next state and the optional result for one raw byte.
module epd_step
  import epd_pkg::*;
(
  input  epd_state_t st,
  input  logic [7:0] raw,
  output epd_state_t st_nxt,
  output logic       res_vld,
  output epd_res_t   res
);

  logic       take;
  logic [7:0] dec;
  logic [7:0] seen_inc;

  assign seen_inc = st.bytes_seen + 8'd1;

  always_comb begin
    st_nxt  = st;
    res_vld = 1'b0;
    res     = '0;
    take    = 1'b0;
    dec     = raw;

    if (raw == SYNC_BYTE) begin
      st_nxt = epd_cleared(PH_ADDR);
    end else if (st.phase == PH_SEEK) begin
      st_nxt = st;
    end else if (st.esc_pending) begin
      st_nxt.esc_pending = 1'b0;
      if (raw == ESC_SYNC) begin
        take = 1'b1;
        dec  = SYNC_BYTE;
      end else if (raw == ESC_MARK) begin
        take = 1'b1;
        dec  = MARK_BYTE;
      end else begin
        res_vld          = 1'b1;
        res.kind         = K_ESC;
        res.node_address = st.held_address;
        res.length_field = st.held_count;
        st_nxt           = epd_cleared(PH_SEEK);
      end
    end else if (raw == MARK_BYTE) begin
      st_nxt.esc_pending = 1'b1;
    end else begin
      take = 1'b1;
    end

    if (take) begin
      case (st.phase)
        PH_ADDR: begin
          st_nxt.held_address = dec;
          st_nxt.running_sum  = dec;
          st_nxt.phase        = PH_COUNT;
        end
        PH_COUNT: begin
          res_vld          = 1'b1;
          res.node_address = st.held_address;
          if (dec == 8'd0) begin
            res.kind         = K_ZERO;
            res.length_field = st.held_count;
            st_nxt           = epd_cleared(PH_SEEK);
          end else begin
            res.kind           = K_START;
            res.length_field   = dec;
            st_nxt.held_count  = dec;
            st_nxt.running_sum = st.running_sum + dec;
            st_nxt.bytes_seen  = 8'd0;
            st_nxt.phase       = PH_DATA;
          end
        end
        PH_DATA: begin
          res_vld          = 1'b1;
          res.node_address = st.held_address;
          res.length_field = st.held_count;
          if (seen_inc < st.held_count) begin
            res.kind           = K_PAYLOAD;
            res.payload_value  = dec;
            st_nxt.running_sum = st.running_sum + dec;
            st_nxt.bytes_seen  = seen_inc;
          end else begin
            // last byte is the checksum
            res.kind         = (st.running_sum == dec) ? K_GOOD : K_CSUM;
            res.expected_sum = st.running_sum;
            res.received_sum = dec;
            st_nxt           = epd_cleared(PH_SEEK);
          end
        end
        default: begin
          st_nxt = st;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/escaped_packet_deframer_unit.sv -----
`timescale 1ns / 1ps

// Escaped packet deframer. Takes one raw link byte per beat on in_byte and
// gives at most one result beat on out_res: a start beat once a nonzero count
// is seen, one beat per decoded payload byte, then an end beat (good,
// checksum fail, bad escape or zero count). Sync 0xE0 restarts framing at any
// point without an end beat; 0xD0 escapes the next byte (0xDF -> 0xE0,
// 0xCF -> 0xD0). Payload beats are tentative until the end beat arrives.
// Throughput is one byte per clock while out_res does not stall: the per-byte
// update is 8-bit adds and compares between the input and result registers.
// A result passes the input register, then the result register; bytes with no
// result retire in the cycle after acceptance. Both sides may stall freely.
module escaped_packet_deframer_unit
  import epd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  epd_in_if.sink          in_byte,
  epd_out_if.source       out_res
);

  // Input register stage
  logic       in_v_r;
  logic [7:0] in_r;

  // Packet state
  epd_state_t st_r;
  epd_state_t st_nxt;

  // Result register
  logic       out_v_r;
  epd_res_t   out_r;

  logic       res_vld;
  epd_res_t   res;
  logic       out_free;
  logic       adv;

  epd_step u_step (
    .st      (st_r),
    .raw     (in_r),
    .st_nxt  (st_nxt),
    .res_vld (res_vld),
    .res     (res)
  );

  // The held byte retires when it makes no result or the result register
  // is empty or being drained this cycle.
  assign out_free = !out_v_r || out_res.ready;
  assign adv      = in_v_r && (!res_vld || out_free);

  assign in_byte.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= epd_cleared(PH_SEEK);
    end else begin
      if (in_byte.ready) begin
        in_v_r <= in_byte.valid;
      end
      if (adv) begin
        st_r <= st_nxt;
      end
      if (adv && res_vld) begin
        out_v_r <= 1'b1;
      end else if (out_res.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_byte.ready && in_byte.valid) begin
      in_r <= in_byte.raw_byte;
    end
    if (adv && res_vld) begin
      out_r <= res;
    end
  end

  assign out_res.valid         = out_v_r;
  assign out_res.kind          = out_r.kind;
  assign out_res.payload_value = out_r.payload_value;
  assign out_res.node_address  = out_r.node_address;
  assign out_res.length_field  = out_r.length_field;
  assign out_res.expected_sum  = out_r.expected_sum;
  assign out_res.received_sum  = out_r.received_sum;

endmodule

// ----- hw/rtl/epd_checker.sv -----
`timescale 1ns / 1ps

module epd_checker
  import epd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [7:0] payload_value,
  input logic [7:0] length_field,
  input logic [7:0] expected_sum,
  input logic [7:0] received_sum
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_value))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> kind <= K_ZERO)
    else $error("result kind out of range");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != K_PAYLOAD |-> payload_value == 8'd0)
    else $error("payload value set on non-payload beat");

  a_sums_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != K_GOOD && kind != K_CSUM |->
      expected_sum == 8'd0 && received_sum == 8'd0)
    else $error("checksum fields set on non-end beat");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == K_START || kind == K_PAYLOAD) |-> length_field != 8'd0)
    else $error("open packet with zero length");

endmodule

bind escaped_packet_deframer_unit epd_checker u_epd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .kind          (out_res.kind),
  .payload_value (out_res.payload_value),
  .length_field  (out_res.length_field),
  .expected_sum  (out_res.expected_sum),
  .received_sum  (out_res.received_sum)
);

// ----- tb/epd_frame_checker.sv -----
`timescale 1ns / 1ps

module epd_frame_checker
  import epd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  epd_in_if    link_ch,
  epd_out_if   res_ch,
  output int   mismatches,
  output int   awaited,
  output int   beats_checked,
  output int   good_packets,
  output int   failed_packets
);

  // Shadow deframer state
  logic [1:0] phase;
  logic       esc_pending;
  logic [7:0] sum_acc;
  logic [7:0] addr_held;
  logic [7:0] count_held;
  logic [7:0] seen;

  epd_res_t expected_beats [$];
  epd_res_t got_beat;
  epd_res_t want_beat;
  int       fail_n = 0;
  int       checked_n = 0;
  int       good_n = 0;
  int       bad_n = 0;

  task automatic forget_packet();
    esc_pending = 1'b0;
    sum_acc     = '0;
    addr_held   = '0;
    count_held  = '0;
    seen        = '0;
  endtask

  task automatic expect_beat(input logic [2:0] kind, input logic [7:0] pay,
                             input logic [7:0] exp_s, input logic [7:0] rcv_s);
    epd_res_t r;
    r.kind          = kind;
    r.payload_value = pay;
    r.node_address  = addr_held;
    r.length_field  = count_held;
    r.expected_sum  = exp_s;
    r.received_sum  = rcv_s;
    expected_beats.push_back(r);
  endtask

  // One raw link byte through the shadow deframer
  task automatic deframe(input logic [7:0] raw);
    logic [7:0] v;
    logic       decoded;
    v       = raw;
    decoded = 1'b0;
    if (raw == SYNC_BYTE) begin
      forget_packet();
      phase = PH_ADDR;
    end else if (phase == PH_SEEK) begin
      decoded = 1'b0;
    end else if (esc_pending) begin
      esc_pending = 1'b0;
      if (raw == ESC_SYNC) begin
        v       = SYNC_BYTE;
        decoded = 1'b1;
      end else if (raw == ESC_MARK) begin
        v       = MARK_BYTE;
        decoded = 1'b1;
      end else begin
        expect_beat(K_ESC, 8'h00, 8'h00, 8'h00);
        forget_packet();
        phase = PH_SEEK;
      end
    end else if (raw == MARK_BYTE) begin
      esc_pending = 1'b1;
    end else begin
      decoded = 1'b1;
    end

    if (decoded) begin
      case (phase)
        PH_ADDR: begin
          addr_held = v;
          sum_acc   = v;
          phase     = PH_COUNT;
        end
        PH_COUNT: begin
          if (v == 8'h00) begin
            expect_beat(K_ZERO, 8'h00, 8'h00, 8'h00);
            forget_packet();
            phase = PH_SEEK;
          end else begin
            count_held = v;
            sum_acc    = sum_acc + v;
            seen       = '0;
            phase      = PH_DATA;
            expect_beat(K_START, 8'h00, 8'h00, 8'h00);
          end
        end
        PH_DATA: begin
          seen = seen + 8'd1;
          if (seen < count_held) begin
            sum_acc = sum_acc + v;
            expect_beat(K_PAYLOAD, v, 8'h00, 8'h00);
          end else begin
            expect_beat((sum_acc == v) ? K_GOOD : K_CSUM, 8'h00, sum_acc, v);
            forget_packet();
            phase = PH_SEEK;
          end
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase = PH_SEEK;
      forget_packet();
      expected_beats.delete();
    end else begin
      if (link_ch.valid && link_ch.ready) begin
        deframe(link_ch.raw_byte);
      end
      if (res_ch.valid && res_ch.ready) begin
        got_beat.kind          = res_ch.kind;
        got_beat.payload_value = res_ch.payload_value;
        got_beat.node_address  = res_ch.node_address;
        got_beat.length_field  = res_ch.length_field;
        got_beat.expected_sum  = res_ch.expected_sum;
        got_beat.received_sum  = res_ch.received_sum;
        checked_n++;
        case (got_beat.kind)
          K_GOOD:                begin good_n++; end
          K_CSUM, K_ESC, K_ZERO: begin bad_n++; end
          default: ;
        endcase
        if (expected_beats.size() == 0) begin
          fail_n++;
          if (fail_n <= 10) begin
            $display({"checker: unexpected beat kind %0d pay %02h addr %02h",
                      " len %02h sums %02h/%02h"},
                     got_beat.kind, got_beat.payload_value, got_beat.node_address,
                     got_beat.length_field, got_beat.expected_sum, got_beat.received_sum);
          end
        end else begin
          want_beat = expected_beats.pop_front();
          if (got_beat !== want_beat) begin
            fail_n++;
            if (fail_n <= 10) begin
              $display({"checker: beat %0d expected kind %0d pay %02h addr %02h",
                        " len %02h sums %02h/%02h"},
                       checked_n, want_beat.kind, want_beat.payload_value,
                       want_beat.node_address, want_beat.length_field,
                       want_beat.expected_sum, want_beat.received_sum);
              $display({"checker: beat %0d got      kind %0d pay %02h addr %02h",
                        " len %02h sums %02h/%02h"},
                       checked_n, got_beat.kind, got_beat.payload_value,
                       got_beat.node_address, got_beat.length_field,
                       got_beat.expected_sum, got_beat.received_sum);
            end
          end
        end
      end
    end
    mismatches     <= fail_n;
    awaited        <= expected_beats.size();
    beats_checked  <= checked_n;
    good_packets   <= good_n;
    failed_packets <= bad_n;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import epd_pkg::*;

  // Far above the slowest legal run (~1k link bytes)
  localparam int LIMIT_CYCLES    = 200000;
  // Framed link bytes per idling mix; three mixes make up the random part
  localparam int ITEMS_PER_PHASE = 235;
  // Length of the one long receiver hold-off
  localparam int HOLD_CYCLES     = 400;
  localparam int OPENING_LEN     = 27;

  logic clk;
  logic rst_n;

  epd_in_if  in_ch ();
  epd_out_if out_ch ();

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic squeeze_req;
  logic squeeze_done = 1'b0;
  int   bytes_sent = 0;
  int   cycle_n = 0;

  int mismatches;
  int awaited;
  int beats_checked;
  int good_packets;
  int failed_packets;

  // Directed opening: every special case once, in link order.
  //   - a stray marker while hunting for sync (ignored)
  //   - address 00 with a count of one: start then straight to a good end
  //   - escaped address (D0) and escaped payload (E0), good checksum B2
  //   - address FF, payload FF, sum wraps to 00 but checksum byte is 55: fail
  //   - zero count
  //   - marker mid-packet followed by a raw sync: packet dropped silently,
  //     then a bad escape straight after sync, in the address phase
  logic [7:0] opening_bytes [OPENING_LEN] = '{
    MARK_BYTE,
    SYNC_BYTE, 8'h00, 8'h01, 8'h01,
    SYNC_BYTE, MARK_BYTE, ESC_MARK, 8'h02, MARK_BYTE, ESC_SYNC, 8'hB2,
    SYNC_BYTE, 8'hFF, 8'h02, 8'hFF, 8'h55,
    SYNC_BYTE, 8'h12, 8'h00,
    SYNC_BYTE, 8'h56, 8'h05, MARK_BYTE, SYNC_BYTE, MARK_BYTE, 8'h00
  };

  escaped_packet_deframer_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_ch),
    .out_res (out_ch)
  );

  // Watches both channels, predicts every result beat and compares
  epd_frame_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .link_ch        (in_ch),
    .res_ch         (out_ch),
    .mismatches     (mismatches),
    .awaited        (awaited),
    .beats_checked  (beats_checked),
    .good_packets   (good_packets),
    .failed_packets (failed_packets)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= LIMIT_CYCLES) begin
      $display("tb: timed out after %0d cycles with %0d results outstanding", cycle_n, awaited);
      $display("tb: FAIL");
      $finish;
    end
  end

  // Result side. Random back-pressure at the current idling rate, plus one
  // long hold-off on request so the deframer fills and stalls its input.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeeze_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One raw beat on the link. Valid stays high from one beat to the next
  // unless the sender decides to idle first.
  task automatic push_link_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.raw_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // A decoded byte as it goes on the wire: sync and marker values escaped
  task automatic push_decoded(input logic [7:0] v);
    if (v == SYNC_BYTE) begin
      push_link_byte(MARK_BYTE);
      push_link_byte(ESC_SYNC);
    end else if (v == MARK_BYTE) begin
      push_link_byte(MARK_BYTE);
      push_link_byte(ESC_MARK);
    end else begin
      push_link_byte(v);
    end
  endtask

  // Framing-sensitive values turn up a quarter of the time
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(15))
      0:       return SYNC_BYTE;
      1:       return MARK_BYTE;
      2:       return ESC_SYNC;
      3:       return ESC_MARK;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Random traffic under one idling mix. Mostly whole packets with random
  // content; the rest is line noise, zero counts, over-long packets, packets
  // cut short by a fresh sync, bad escapes and corrupted checksums.
  task automatic run_phase(input int s_pct, input int r_pct);
    int         framed;
    int         before_n;
    int         mode;
    int         damage_at;
    int         i;
    logic [7:0] addr;
    logic [7:0] cnt;
    logic [7:0] sum;
    logic [7:0] b;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    framed        = 0;
    while (framed < ITEMS_PER_PHASE) begin
      mode     = $urandom_range(99);
      before_n = bytes_sent;
      if (mode < 15) begin
        // noise: mostly swallowed while hunting, or absorbed into a packet
        repeat ($urandom_range(1, 4)) push_link_byte(8'($urandom_range(255)));
      end else begin
        push_link_byte(SYNC_BYTE);
        addr = pick_byte();
        push_decoded(addr);
        if (mode < 20) cnt = 8'h00;
        else if (mode < 22) cnt = 8'($urandom_range(9, 255));
        else cnt = 8'($urandom_range(1, 8));
        push_decoded(cnt);
        sum       = addr + cnt;
        damage_at = (cnt == 8'h00) ? 0 : $urandom_range(1, cnt);
        for (i = 1; i <= cnt; i++) begin
          if (i == damage_at && mode >= 22 && mode < 38) begin
            if (mode >= 30) begin
              // marker followed by something that is not a valid escape
              do b = 8'($urandom_range(255));
              while (b == ESC_SYNC || b == ESC_MARK || b == SYNC_BYTE);
              push_link_byte(MARK_BYTE);
              push_link_byte(b);
            end
            // otherwise just stop: the next sync cuts the packet off
            break;
          end
          if (i < cnt) begin
            b   = pick_byte();
            sum = sum + b;
            push_decoded(b);
          end else begin
            b = (mode < 50) ? (sum ^ 8'($urandom_range(1, 255))) : sum;
            push_decoded(b);
          end
        end
        framed += bytes_sent - before_n;
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.raw_byte <= 8'h00;
    squeeze_req    <= 1'b0;
    send_idle_pct  = 19;
    recv_idle_pct  = 72;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_bytes[k]) push_link_byte(opening_bytes[k]);

    run_phase(19, 72);
    run_phase(72, 19);
    // no idling on either side, with the long receiver hold-off early on
    squeeze_req <= 1'b1;
    run_phase(0, 0);
    in_ch.valid <= 1'b0;

    // Drain: wait until every expected result has arrived, then a short tail
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d link bytes over three idling mixes and one long hold-off, %0d result beats",
             bytes_sent, beats_checked);
    $display("tb: %0d packets ended good, %0d ended in a checksum, escape or count error",
             good_packets, failed_packets);
    if (awaited != 0) begin
      $display("tb: %0d expected results never arrived", awaited);
    end
    if (mismatches == 0 && awaited == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/epd_pkg.sv
hw/rtl/epd_ifs.sv
hw/rtl/epd_step.sv
hw/rtl/escaped_packet_deframer_unit.sv
hw/rtl/epd_checker.sv
tb/epd_frame_checker.sv
tb/tb.sv
